[rtl/core/arpc_pkg.sv]
`default_nettype none
package arpc_pkg;
   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_RECV = 2'd1;
   localparam logic [1:0] ACT_SEND = 2'd2;
   localparam logic [1:0] ACT_DROP = 2'd3;

   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_FRAME   = 3'd1;
   localparam logic [2:0] KIND_REQUEST = 3'd2;
   localparam logic [2:0] KIND_REPLY   = 3'd3;
   localparam logic [2:0] KIND_RELEASE = 3'd4;

   localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
   localparam logic [15:0] ETHERTYPE_IP  = 16'h0800;
   localparam logic [15:0] OP_REQUEST    = 16'd1;
   localparam logic [15:0] OP_REPLY      = 16'd2;
   localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

   localparam logic CSR_LOCAL_IP = 1'b0;
   localparam logic CSR_TIMEOUT  = 1'b1;

   typedef struct packed {
      logic [1:0]  action;
      logic        is_request;
      logic [31:0] src_ip;
      logic [47:0] src_mac;
      logic [31:0] tgt_ip;
      logic [31:0] next_hop_ip;
      logic [15:0] protocol;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [47:0] dst_mac;
      logic [31:0] ip_addr;
      logic [15:0] frame_protocol;
   } rsp_type;
endpackage
`default_nettype wire

[rtl/core/arp_cache_resolver.sv]
// Channel  Handshake              Payload
// req      req_push / req_full    action, ARP header fields, next hop, protocol
// rsp      rsp_pop / rsp_empty    result kind, MAC, IP, ethertype
// csr      csr_valid / csr_ready  register index, write data
// A received header runs the age, pick and look sweeps and the done state before its result.
// A send runs the look sweep and the done state; a tick or rejected header is answered on acceptance.
// The table sweeps share one entry index counter in the back end.
// Reset is synchronous and clears the table valid bits at once.
// A full result register stalls the back end; the front queue holds two requests.
`default_nettype none
module arp_cache_resolver #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_action,
   input  wire logic [15:0] req_hw_type,
   input  wire logic [15:0] req_pro_type,
   input  wire logic [7:0]  req_hw_len,
   input  wire logic [7:0]  req_pro_len,
   input  wire logic [15:0] req_opcode,
   input  wire logic [31:0] req_src_ip,
   input  wire logic [47:0] req_src_mac,
   input  wire logic [31:0] req_tgt_ip,
   input  wire logic [31:0] req_next_hop_ip,
   input  wire logic [15:0] req_protocol,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [2:0]       rsp_result_kind,
   output logic [47:0]      rsp_dst_mac,
   output logic [31:0]      rsp_ip_addr,
   output logic [15:0]      rsp_frame_protocol,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);
   logic [31:0] local_ip_ff;
   logic [15:0] timeout_ff;
   logic cmd_valid, cmd_ready, rsp_valid;
   arpc_pkg::cmd_type cmd;
   arpc_pkg::rsp_type rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff <= '0;
         timeout_ff  <= 16'd60;
      end else if (csr_valid) begin
         case (csr_index)
            arpc_pkg::CSR_LOCAL_IP: local_ip_ff <= csr_data;
            arpc_pkg::CSR_TIMEOUT:  timeout_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   arpc_front u_front (
      .clock, .reset, .req_push, .req_full, .req_action, .req_hw_type, .req_pro_type,
      .req_hw_len, .req_pro_len, .req_opcode, .req_src_ip, .req_src_mac,
      .req_tgt_ip, .req_next_hop_ip, .req_protocol,
      .cmd_valid, .cmd_ready, .cmd
   );

   arpc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock, .reset, .local_ip(local_ip_ff), .timeout_seconds(timeout_ff),
      .cmd_valid, .cmd_ready, .cmd,
      .rsp_valid, .rsp_taken(rsp_pop), .rsp
   );

   assign rsp_empty          = !rsp_valid;
   assign rsp_result_kind    = rsp.kind;
   assign rsp_dst_mac        = rsp.dst_mac;
   assign rsp_ip_addr        = rsp.ip_addr;
   assign rsp_frame_protocol = rsp.frame_protocol;
endmodule
`default_nettype wire

[rtl/core/arpc_front.sv]
`default_nettype none
module arpc_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   output logic                 req_full,
   input  wire logic [1:0]      req_action,
   input  wire logic [15:0]     req_hw_type,
   input  wire logic [15:0]     req_pro_type,
   input  wire logic [7:0]      req_hw_len,
   input  wire logic [7:0]      req_pro_len,
   input  wire logic [15:0]     req_opcode,
   input  wire logic [31:0]     req_src_ip,
   input  wire logic [47:0]     req_src_mac,
   input  wire logic [31:0]     req_tgt_ip,
   input  wire logic [31:0]     req_next_hop_ip,
   input  wire logic [15:0]     req_protocol,
   output logic                 cmd_valid,
   input  wire logic            cmd_ready,
   output arpc_pkg::cmd_type    cmd
);
   // Two-entry queue of classified commands; rejected headers become no-ops.
   arpc_pkg::cmd_type q_ff [2];
   arpc_pkg::cmd_type q_in;
   logic [1:0] cnt_ff;
   logic rd_ff, wr_ff;
   logic hdr_ok, push_ok, pop_ok;

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_valid && cmd_ready;

   always_comb begin
      hdr_ok = (req_hw_type == 16'd1) && (req_pro_type == arpc_pkg::ETHERTYPE_IP) &&
               (req_hw_len == 8'd6) && (req_pro_len == 8'd4) &&
               ((req_opcode == arpc_pkg::OP_REQUEST) || (req_opcode == arpc_pkg::OP_REPLY));
      q_in.action      = req_action;
      if (req_action == arpc_pkg::ACT_RECV && !hdr_ok) begin
         q_in.action = arpc_pkg::ACT_DROP;
      end
      q_in.is_request  = (req_opcode == arpc_pkg::OP_REQUEST);
      q_in.src_ip      = req_src_ip;
      q_in.src_mac     = req_src_mac;
      q_in.tgt_ip      = req_tgt_ip;
      q_in.next_hop_ip = req_next_hop_ip;
      q_in.protocol    = req_protocol;
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ff] <= q_in;
      end
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         if (push_ok) wr_ff <= !wr_ff;
         if (pop_ok)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok};
      end
   end
endmodule
`default_nettype wire

[rtl/core/arpc_back.sv]
`default_nettype none
module arpc_back #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [31:0]     local_ip,
   input  wire logic [15:0]     timeout_seconds,
   input  wire logic            cmd_valid,
   output logic                 cmd_ready,
   input  wire arpc_pkg::cmd_type cmd,
   output logic                 rsp_valid,
   input  wire logic            rsp_taken,
   output arpc_pkg::rsp_type    rsp
);
   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IW:0] LAST = (IW+1)'(TABLE_ENTRIES - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_AGE   = 3'd1;
   localparam logic [2:0] ST_PICK  = 3'd2;
   localparam logic [2:0] ST_LOOK  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [IW:0] idx_ff, idx_in;
   arpc_pkg::cmd_type cur_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [31:0] ip_ff [TABLE_ENTRIES];
   logic [47:0] mac_ff [TABLE_ENTRIES];
   logic [31:0] stamp_ff [TABLE_ENTRIES];
   logic [31:0] now_ff;
   logic        pend_ff;
   logic [31:0] pend_ip_ff;
   logic [15:0] pend_proto_ff;
   logic [IW-1:0] slot_ff;
   logic        free_ff;
   logic [31:0] worst_ff;
   logic        hit_ff;
   logic [IW-1:0] hit_idx_ff;
   logic [31:0] look_ip_ff;
   logic        rv_ff;
   arpc_pkg::rsp_type rsp_ff, rsp_in;

   logic [IW-1:0] ix;
   logic [31:0]   age;
   logic          last;
   logic [IW-1:0] pick;

   assign ix        = idx_ff[IW-1:0];
   assign age       = now_ff - stamp_ff[ix];
   assign last      = (idx_ff == LAST);
   assign cmd_ready = (state_ff == ST_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp       = rsp_ff;

   // The entry examined in the last pick cycle still has to be weighed here.
   always_comb begin
      pick = slot_ff;
      if (!free_ff && (!valid_ff[ix] || ix == '0 || age > worst_ff)) begin
         pick = ix;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff + 1'b1;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (cmd_valid && cmd_ready) begin
               case (cmd.action)
                  arpc_pkg::ACT_RECV: state_in = ST_AGE;
                  arpc_pkg::ACT_SEND: state_in = ST_LOOK;
                  default:            state_in = ST_IDLE;
               endcase
            end
         end
         ST_AGE:  if (last) begin state_in = ST_PICK; idx_in = '0; end
         ST_PICK: if (last) begin state_in = ST_LOOK; idx_in = '0; end
         ST_LOOK: if (last) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_in = '{arpc_pkg::KIND_NONE, 48'd0, 32'd0, 16'd0};
      if (cur_ff.action == arpc_pkg::ACT_SEND) begin
         if (hit_ff) begin
            rsp_in = '{arpc_pkg::KIND_FRAME, mac_ff[hit_idx_ff], cur_ff.next_hop_ip,
                       cur_ff.protocol};
         end else begin
            rsp_in = '{arpc_pkg::KIND_REQUEST, arpc_pkg::MAC_BROADCAST,
                       cur_ff.next_hop_ip, arpc_pkg::ETHERTYPE_ARP};
         end
      end else if (pend_ff && hit_ff) begin
         rsp_in = '{arpc_pkg::KIND_RELEASE, mac_ff[hit_idx_ff], pend_ip_ff, pend_proto_ff};
      end else if (cur_ff.is_request && cur_ff.tgt_ip == local_ip) begin
         rsp_in = '{arpc_pkg::KIND_REPLY, cur_ff.src_mac, cur_ff.src_ip,
                    arpc_pkg::ETHERTYPE_ARP};
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            cur_ff   <= cmd;
            free_ff  <= 1'b0;
            slot_ff  <= '0;
            worst_ff <= '0;
            hit_ff   <= 1'b0;
            look_ip_ff <= (cmd.action == arpc_pkg::ACT_SEND) ? cmd.next_hop_ip : pend_ip_ff;
         end
         ST_PICK: begin
            if (!free_ff) begin
               if (!valid_ff[ix]) begin
                  free_ff <= 1'b1;
                  slot_ff <= ix;
               end else if (ix == '0 || age > worst_ff) begin
                  worst_ff <= age;
                  slot_ff  <= ix;
               end
            end
         end
         ST_LOOK: begin
            if (!hit_ff && valid_ff[ix] && ip_ff[ix] == look_ip_ff) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= ix;
            end
         end
         default: ;
      endcase
      if (state_ff == ST_PICK && last) begin
         ip_ff[pick]  <= cur_ff.src_ip;
         mac_ff[pick] <= cur_ff.src_mac;
      end
      if (state_ff == ST_DONE) begin
         rsp_ff <= rsp_in;
      end else if (state_ff == ST_IDLE && cmd_valid && cmd_ready) begin
         rsp_ff <= '{arpc_pkg::KIND_NONE, 48'd0, 32'd0, 16'd0};
      end
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         valid_ff      <= '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) stamp_ff[i] <= '0;
         now_ff        <= '0;
         pend_ff       <= 1'b0;
         pend_ip_ff    <= '0;
         pend_proto_ff <= '0;
         rv_ff         <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (state_ff == ST_IDLE && cmd_valid && cmd_ready) begin
            if (cmd.action == arpc_pkg::ACT_TICK) now_ff <= now_ff + 32'd1;
            if (cmd.action != arpc_pkg::ACT_RECV && cmd.action != arpc_pkg::ACT_SEND) begin
               rv_ff <= 1'b1;
            end
         end
         if (state_ff == ST_AGE && age > {16'd0, timeout_seconds}) valid_ff[ix] <= 1'b0;
         if (state_ff == ST_PICK && last) begin
            valid_ff[pick] <= 1'b1;
            stamp_ff[pick] <= now_ff;
         end
         if (state_ff == ST_DONE) begin
            rv_ff <= 1'b1;
            if (cur_ff.action == arpc_pkg::ACT_SEND) begin
               if (!hit_ff) begin
                  pend_ff       <= 1'b1;
                  pend_ip_ff    <= cur_ff.next_hop_ip;
                  pend_proto_ff <= cur_ff.protocol;
               end
            end else if (pend_ff && hit_ff) begin
               pend_ff <= 1'b0;
            end
         end
         if (rv_ff && rsp_taken) rv_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire
